[src/bsrp_pkg.sv]
// ---------------------------------------------------------------------------
// bsrp_pkg: shared types and constants for the B/S rule string parser
// Character codes, token classes, status codes, register indexes and the
// structs that pass between the front end, the token queue and the parser.
// ---------------------------------------------------------------------------
package bsrp_pkg;

    // token queue between front end and parser
    localparam int TOK_DEPTH = 4;
    localparam int TOK_PTR_W = $clog2(TOK_DEPTH);
    localparam int TOK_CNT_W = $clog2(TOK_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_B_UP = 8'h42;
    localparam logic [7:0] CH_B_LO = 8'h62;
    localparam logic [7:0] CH_S_UP = 8'h53;
    localparam logic [7:0] CH_S_LO = 8'h73;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // token classes
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_BIRTH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SURV = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SLASH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIGIT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_NO_B = 3'd2;
    localparam logic [2:0] ST_BADCHAR = 3'd3;
    localparam logic [2:0] ST_NO_SURV = 3'd4;
    localparam logic [2:0] ST_NO_S = 3'd5;
    localparam logic [2:0] ST_BADGEN = 3'd6;

    // configuration register indexes
    localparam logic REG_MAX_GENS = 1'b0;
    localparam logic REG_DEF_GENS = 1'b1;

    localparam logic [7:0] MAX_GENS_RST = 8'd60;
    localparam logic [7:0] DEF_GENS_RST = 8'd2;

    typedef struct packed {
        logic              is_end;
        logic [KIND_W-1:0] kind;
        logic [3:0]        digit;
    } tok_t;

    typedef struct packed {
        logic [7:0] max_gens;
        logic [7:0] def_gens;
    } cfg_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] birth_mask;
        logic [9:0] survive_mask;
        logic [7:0] generations;
    } result_t;

endpackage

[src/bsrp_front.sv]
// ---------------------------------------------------------------------------
// bsrp_front: input acceptance and character classification
// Turns each accepted item into a token (end marker or character class
// with digit value) and pushes it into the token queue.
// ---------------------------------------------------------------------------
module bsrp_front (
    input  logic                push,
    input  logic                action,
    input  logic [7:0]          char_code,
    input  logic                tok_full,
    output logic                tok_push,
    output bsrp_pkg::tok_t      tok
);

    logic [7:0] digit_off;

    assign tok_push = push && !tok_full;
    assign digit_off = char_code - bsrp_pkg::CH_ZERO;

    always_comb
    begin
        tok.is_end = action;
        tok.digit = digit_off[3:0];
        case (char_code) inside
            bsrp_pkg::CH_B_UP, bsrp_pkg::CH_B_LO:
                tok.kind = bsrp_pkg::KIND_BIRTH;
            bsrp_pkg::CH_S_UP, bsrp_pkg::CH_S_LO:
                tok.kind = bsrp_pkg::KIND_SURV;
            bsrp_pkg::CH_SLASH:
                tok.kind = bsrp_pkg::KIND_SLASH;
            [bsrp_pkg::CH_ZERO:bsrp_pkg::CH_NINE]:
                tok.kind = bsrp_pkg::KIND_DIGIT;
            default:
                tok.kind = bsrp_pkg::KIND_OTHER;
        endcase
    end

endmodule

[src/bsrp_tok_fifo.sv]
// ---------------------------------------------------------------------------
// bsrp_tok_fifo: token queue between front end and parser
// Small circular buffer; the head entry is visible while tok_valid is high.
// ---------------------------------------------------------------------------
module bsrp_tok_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bsrp_pkg::tok_t wr_tok,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output bsrp_pkg::tok_t rd_tok
);

    bsrp_pkg::tok_t entry_reg [bsrp_pkg::TOK_DEPTH];

    logic [bsrp_pkg::TOK_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bsrp_pkg::TOK_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bsrp_pkg::TOK_CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == bsrp_pkg::TOK_CNT_W'(bsrp_pkg::TOK_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_tok = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

[src/bsrp_back.sv]
// ---------------------------------------------------------------------------
// bsrp_back: rule parser and result register
// Walks the token stream through the rule grammar, builds the masks and
// the generation count, and loads one result per end token.
// ---------------------------------------------------------------------------
module bsrp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bsrp_pkg::cfg_t    cfg,
    input  logic              tok_valid,
    input  bsrp_pkg::tok_t    tok,
    output logic              tok_pop,
    output logic              out_valid,
    output bsrp_pkg::result_t out_res,
    input  logic              out_pop
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_BIRTH = 3'd1;
    localparam logic [2:0] PH_WANT_S = 3'd2;
    localparam logic [2:0] PH_SURVIVE = 3'd3;
    localparam logic [2:0] PH_GENS = 3'd4;
    localparam logic [2:0] PH_ERROR = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic [9:0] birth_reg, birth_next;
    logic [9:0] survive_reg, survive_next;
    logic [7:0] acc_reg, acc_next;
    logic [2:0] err_reg, err_next;
    logic       out_valid_reg, out_valid_next;
    bsrp_pkg::result_t out_reg, out_next;

    logic       out_free;
    logic [11:0] acc_x10;
    logic [7:0] acc_sat;
    logic [2:0] end_status;
    logic [7:0] end_gens;

    assign out_free = !out_valid_reg || out_pop;
    assign tok_pop = tok_valid && (!tok.is_end || out_free);
    assign out_valid = out_valid_reg;
    assign out_res = out_reg;

    // acc * 10 + digit, saturating at 255
    assign acc_x10 = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {8'd0, tok.digit};
    assign acc_sat = (acc_x10 > 12'd255) ? 8'hFF : acc_x10[7:0];

    always_comb
    begin
        end_gens = '0;
        case (phase_reg)
            PH_START:   end_status = bsrp_pkg::ST_EMPTY;
            PH_BIRTH:   end_status = bsrp_pkg::ST_NO_SURV;
            PH_WANT_S:  end_status = bsrp_pkg::ST_NO_S;
            PH_SURVIVE:
            begin
                end_status = bsrp_pkg::ST_OK;
                end_gens = cfg.def_gens;
            end
            PH_GENS:
            begin
                if (acc_reg == 8'd0 || acc_reg > cfg.max_gens)
                begin
                    end_status = bsrp_pkg::ST_BADGEN;
                end
                else
                begin
                    end_status = bsrp_pkg::ST_OK;
                    end_gens = acc_reg;
                end
            end
            default:    end_status = err_reg;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        birth_next = birth_reg;
        survive_next = survive_reg;
        acc_next = acc_reg;
        err_next = err_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !out_pop;

        if (tok_pop && tok.is_end)
        begin
            out_valid_next = 1'b1;
            out_next.status = end_status;
            if (end_status == bsrp_pkg::ST_OK)
            begin
                out_next.birth_mask = birth_reg;
                out_next.survive_mask = survive_reg;
                out_next.generations = end_gens;
            end
            else
            begin
                out_next.birth_mask = '0;
                out_next.survive_mask = '0;
                out_next.generations = '0;
            end
            phase_next = PH_START;
            birth_next = '0;
            survive_next = '0;
            acc_next = '0;
            err_next = bsrp_pkg::ST_OK;
        end
        else if (tok_pop)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (tok.kind == bsrp_pkg::KIND_BIRTH)
                    begin
                        phase_next = PH_BIRTH;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next = bsrp_pkg::ST_NO_B;
                    end
                end
                PH_BIRTH, PH_SURVIVE:
                begin
                    if (tok.kind == bsrp_pkg::KIND_SLASH)
                    begin
                        phase_next = (phase_reg == PH_BIRTH) ? PH_WANT_S : PH_GENS;
                    end
                    else if (tok.kind == bsrp_pkg::KIND_DIGIT)
                    begin
                        if (phase_reg == PH_BIRTH)
                        begin
                            birth_next = birth_reg | (10'd1 << tok.digit);
                        end
                        else
                        begin
                            survive_next = survive_reg | (10'd1 << tok.digit);
                        end
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next = bsrp_pkg::ST_BADCHAR;
                    end
                end
                PH_WANT_S:
                begin
                    if (tok.kind == bsrp_pkg::KIND_SURV)
                    begin
                        phase_next = PH_SURVIVE;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next = bsrp_pkg::ST_NO_S;
                    end
                end
                PH_GENS:
                begin
                    if (tok.kind == bsrp_pkg::KIND_DIGIT)
                    begin
                        acc_next = acc_sat;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        err_next = bsrp_pkg::ST_BADCHAR;
                    end
                end
                default:
                begin
                    // error latched: characters dropped until the end token
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            birth_reg <= '0;
            survive_reg <= '0;
            acc_reg <= '0;
            err_reg <= bsrp_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            birth_reg <= birth_next;
            survive_reg <= survive_next;
            acc_reg <= acc_next;
            err_reg <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[src/birth_survive_rule_parser_core.sv]
// ---------------------------------------------------------------------------
// birth_survive_rule_parser_core: B<digits>/S<digits>[/<gens>] rule parser
// Takes one rule character per item; an end item yields status, masks and
// the generation count.
// ---------------------------------------------------------------------------
// One item is accepted per clock while full is low. Items are classified
// on entry and pass through a four-entry token queue to the parser, which
// retires one token per cycle unless stalled and registers a result as it
// takes an end token. The parser holds an end token only while the result
// register still holds an untaken result, so full rises only after the
// queue fills behind such a stall. Configuration writes are always taken
// (cfg_ready is tied high) and should be made while no rule is in flight.
module birth_survive_rule_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       action,
    input  logic [7:0] char_code,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] status,
    output logic [9:0] birth_mask,
    output logic [9:0] survive_mask,
    output logic [7:0] generations,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    bsrp_pkg::cfg_t    cfg_reg;
    bsrp_pkg::tok_t    in_tok;
    bsrp_pkg::tok_t    head_tok;
    bsrp_pkg::result_t res;
    logic              tok_push;
    logic              tok_full;
    logic              tok_valid;
    logic              tok_pop;
    logic              out_valid;

    assign cfg_ready = 1'b1;
    assign full = tok_full;
    assign empty = !out_valid;
    assign status = res.status;
    assign birth_mask = res.birth_mask;
    assign survive_mask = res.survive_mask;
    assign generations = res.generations;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_gens <= bsrp_pkg::MAX_GENS_RST;
            cfg_reg.def_gens <= bsrp_pkg::DEF_GENS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bsrp_pkg::REG_MAX_GENS: cfg_reg.max_gens <= cfg_data;
                bsrp_pkg::REG_DEF_GENS: cfg_reg.def_gens <= cfg_data;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    bsrp_front u_front (
        .push      (push),
        .action    (action),
        .char_code (char_code),
        .tok_full  (tok_full),
        .tok_push  (tok_push),
        .tok       (in_tok)
    );

    bsrp_tok_fifo u_tok_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tok_push),
        .wr_tok   (in_tok),
        .full     (tok_full),
        .rd_en    (tok_pop),
        .rd_valid (tok_valid),
        .rd_tok   (head_tok)
    );

    bsrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_valid (tok_valid),
        .tok       (head_tok),
        .tok_pop   (tok_pop),
        .out_valid (out_valid),
        .out_res   (res),
        .out_pop   (pop)
    );

endmodule

[src/bsrp_checker.sv]
// ---------------------------------------------------------------------------
// bsrp_checker: port-level checks for the rule parser
// Watches the result and configuration ports of the top level.
// ---------------------------------------------------------------------------
module bsrp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] status,
    input logic [9:0] birth_mask,
    input logic [9:0] survive_mask,
    input logic [7:0] generations,
    input logic       cfg_ready
);

    // a failed parse reports no masks and no count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != bsrp_pkg::ST_OK) |->
        (birth_mask == 10'd0 && survive_mask == 10'd0 && generations == 8'd0))
        else $error("error result carries nonzero payload");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= bsrp_pkg::ST_BADGEN))
        else $error("status code out of range");

    // a waiting result holds until its transfer
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(birth_mask)
        && $stable(survive_mask) && $stable(generations)))
        else $error("result changed before transfer");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind birth_survive_rule_parser_core bsrp_checker u_bsrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .birth_mask   (birth_mask),
    .survive_mask (survive_mask),
    .generations  (generations),
    .cfg_ready    (cfg_ready)
);

[tb/tb_birth_survive_rule_parser_core.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_birth_survive_rule_parser_core: self-checking bench for the rule parser
// Feeds rule strings one character per transfer, predicts each end-of-rule
// verdict with a local parser model and compares every popped result field
// by field. Covers directed error cases, register extremes, a long output
// stall and random rules under three idling mixes.
// ---------------------------------------------------------------------------
module tb_birth_survive_rule_parser_core;

    localparam logic ACT_CHAR      = 1'b0;
    localparam logic ACT_END       = 1'b1;
    localparam int   SETTLE_CYCLES = 12;
    localparam int   STALL_CYCLES  = 150;
    localparam int   TIMEOUT_NS    = 2_000_000;

    // model parse phases
    localparam logic [2:0] S_EXPECT_B = 3'd0;
    localparam logic [2:0] S_BIRTH    = 3'd1;
    localparam logic [2:0] S_EXPECT_S = 3'd2;
    localparam logic [2:0] S_SURVIVE  = 3'd3;
    localparam logic [2:0] S_GENS     = 3'd4;
    localparam logic [2:0] S_FAILED   = 3'd5;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       action    = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic       pop       = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       full;
    logic       empty;
    logic [2:0] status;
    logic [9:0] birth_mask;
    logic [9:0] survive_mask;
    logic [7:0] generations;
    logic       cfg_ready;

    // parser model state
    logic [2:0]   rule_phase;
    logic [9:0]   birth_seen;
    logic [9:0]   survive_seen;
    int           gen_count;
    logic [2:0]   first_error;
    logic [7:0]   gen_limit;
    logic [7:0]   gen_default;

    bsrp_pkg::result_t rule_verdicts[$];
    logic [7:0]        rule_chars[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int stall_req     = 0;
    int stall_ack     = 0;
    int items_sent    = 0;
    int errors        = 0;

    birth_survive_rule_parser_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .char_code    (char_code),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .birth_mask   (birth_mask),
        .survive_mask (survive_mask),
        .generations  (generations),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // ---------------- parser model ----------------
    function automatic void clear_parse();
        rule_phase   = S_EXPECT_B;
        birth_seen   = '0;
        survive_seen = '0;
        gen_count    = 0;
        first_error  = bsrp_pkg::ST_OK;
    endfunction

    function automatic void set_error(input logic [2:0] code);
        first_error = code;
        rule_phase  = S_FAILED;
    endfunction

    task automatic advance_parse(input logic act, input logic [7:0] ch);
        logic              is_num;
        int                val;
        bsrp_pkg::result_t verdict;
        is_num = (ch >= bsrp_pkg::CH_ZERO) && (ch <= bsrp_pkg::CH_NINE);
        val    = int'(ch) - int'(bsrp_pkg::CH_ZERO);
        if (act == ACT_CHAR)
        begin
            case (rule_phase)
                S_EXPECT_B:
                    if (ch == bsrp_pkg::CH_B_UP || ch == bsrp_pkg::CH_B_LO)
                        rule_phase = S_BIRTH;
                    else set_error(bsrp_pkg::ST_NO_B);
                S_BIRTH:
                    if (ch == bsrp_pkg::CH_SLASH) rule_phase = S_EXPECT_S;
                    else if (is_num) birth_seen[ch[3:0]] = 1'b1;
                    else set_error(bsrp_pkg::ST_BADCHAR);
                S_EXPECT_S:
                    if (ch == bsrp_pkg::CH_S_UP || ch == bsrp_pkg::CH_S_LO)
                        rule_phase = S_SURVIVE;
                    else set_error(bsrp_pkg::ST_NO_S);
                S_SURVIVE:
                    if (ch == bsrp_pkg::CH_SLASH) rule_phase = S_GENS;
                    else if (is_num) survive_seen[ch[3:0]] = 1'b1;
                    else set_error(bsrp_pkg::ST_BADCHAR);
                S_GENS:
                    if (is_num)
                    begin
                        gen_count = gen_count * 10 + val;
                        if (gen_count > 255)
                            gen_count = 255;
                    end
                    else
                        set_error(bsrp_pkg::ST_BADCHAR);
                default: ;
            endcase
        end
        else
        begin
            verdict = '0;
            case (rule_phase)
                S_EXPECT_B: set_error(bsrp_pkg::ST_EMPTY);
                S_BIRTH:    set_error(bsrp_pkg::ST_NO_SURV);
                S_EXPECT_S: set_error(bsrp_pkg::ST_NO_S);
                S_SURVIVE:  verdict.generations = gen_default;
                S_GENS:
                    if (gen_count < 1 || gen_count > int'(gen_limit))
                        set_error(bsrp_pkg::ST_BADGEN);
                    else verdict.generations = 8'(gen_count);
                default: ;
            endcase
            if (rule_phase == S_FAILED)
            begin
                verdict        = '0;
                verdict.status = first_error;
            end
            else
            begin
                verdict.status       = bsrp_pkg::ST_OK;
                verdict.birth_mask   = birth_seen;
                verdict.survive_mask = survive_seen;
            end
            rule_verdicts = {rule_verdicts, verdict};
            clear_parse();
        end
    endtask

    // ---------------- result checking ----------------
    function automatic void note_error(input string msg);
        if (errors < 10)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
            note_error($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    task automatic check_result();
        bsrp_pkg::result_t want;
        if (rule_verdicts.size() == 0)
        begin
            note_error($sformatf("unexpected result, status %0d", status));
            return;
        end
        want = rule_verdicts.pop_front();
        check_field("status", int'(want.status), int'(status));
        check_field("birth_mask", int'(want.birth_mask), int'(birth_mask));
        check_field("survive_mask", int'(want.survive_mask), int'(survive_mask));
        check_field("generations", int'(want.generations), int'(generations));
    endtask

    // outputs are sampled at the edge, before the block updates them
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_result();
        pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // long output stall counter
    always @(posedge clk)
    begin
        if (stall_req != stall_ack)
        begin
            hold_left <= STALL_CYCLES;
            stall_ack <= stall_req;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ---------------- drivers ----------------
    task automatic send_item(input logic act, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        action    <= act;
        char_code <= ch;
        do @(posedge clk); while (full);
        items_sent++;
        advance_parse(act, ch);
    endtask

    task automatic send_rule();
        foreach (rule_chars[i])
            send_item(ACT_CHAR, rule_chars[i]);
        send_item(ACT_END, 8'($urandom_range(255)));
    endtask

    function automatic void add_char(input logic [7:0] ch);
        rule_chars = {rule_chars, ch};
    endfunction

    task automatic run_text(input string txt);
        rule_chars.delete();
        foreach (txt[i])
            add_char(txt[i]);
        send_rule();
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (rule_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] max_val, input logic [7:0] def_val);
        cfg_valid <= 1'b1;
        cfg_index <= bsrp_pkg::REG_MAX_GENS;
        cfg_data  <= max_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= bsrp_pkg::REG_DEF_GENS;
        cfg_data  <= def_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        gen_limit   = max_val;
        gen_default = def_val;
    endtask

    // ---------------- random rule builder ----------------
    task automatic add_digits(input int n);
        repeat (n) add_char(8'(bsrp_pkg::CH_ZERO + $urandom_range(9)));
    endtask

    task automatic add_count();
        int unsigned v;
        string       txt;
        case ($urandom_range(3))
            0:       v = $urandom_range(gen_limit);
            1:       v = $urandom_range(300);
            2:       v = $urandom_range(99999);
            default: v = gen_limit + $urandom_range(1);
        endcase
        txt = $sformatf("%0d", v);
        if ($urandom_range(7) == 0)
            txt = {"00", txt};
        if ($urandom_range(9) == 0)
            txt = "";
        foreach (txt[i])
            add_char(txt[i]);
    endtask

    task automatic build_random_rule();
        int kind;
        int pos;
        rule_chars.delete();
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            repeat ($urandom_range(6)) add_char(8'($urandom_range(255)));
            return;
        end
        add_char($urandom_range(1) ? bsrp_pkg::CH_B_UP : bsrp_pkg::CH_B_LO);
        add_digits($urandom_range(6));
        add_char(bsrp_pkg::CH_SLASH);
        add_char($urandom_range(1) ? bsrp_pkg::CH_S_UP : bsrp_pkg::CH_S_LO);
        add_digits($urandom_range(6));
        if ($urandom_range(2) != 0)
        begin
            add_char(bsrp_pkg::CH_SLASH);
            add_count();
        end
        // broken rules: one byte overwritten, or the string cut short
        if (kind < 30)
        begin
            pos = $urandom_range(rule_chars.size() - 1);
            if ($urandom_range(1))
                rule_chars[pos] = 8'($urandom_range(255));
            else
                while (rule_chars.size() > pos)
                    void'(rule_chars.pop_back());
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_rule_errors();
        run_text("");
        run_text("x");
        run_text("b");
        run_text("B/");
        run_text("B1a");
        run_text("B/s/");
        run_text("b9/S0");
        run_text("B3/S23/45");
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_config(8'd255, 8'd0);
        run_text("B/S/99999");
        run_text("B012/S");
        run_text("B/S/0");
        wait_idle();
        set_config(8'd0, 8'd255);
        run_text("B/S/1");
        run_text("b/s");
        wait_idle();
        set_config(8'd1, 8'd1);
        run_text("B/S/1");
        run_text("B/S/2");
        run_text("B0123456789/S9876543210");
    endtask

    task automatic test_output_stall();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        stall_req++;
        repeat (12)
        begin
            build_random_rule();
            send_rule();
        end
        send_idle_pct = saved_pct;
    endtask

    task automatic test_random_rules(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n)
        begin
            build_random_rule();
            send_rule();
        end
    endtask

    initial
    begin
        gen_limit   = bsrp_pkg::MAX_GENS_RST;
        gen_default = bsrp_pkg::DEF_GENS_RST;
        clear_parse();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 45;
        test_rule_errors();
        test_register_extremes();
        wait_idle();
        set_config(8'd255, 8'($urandom_range(1, 255)));
        test_output_stall();
        test_random_rules(500);

        wait_idle();
        set_config(8'($urandom_range(1, 255)), 8'($urandom_range(255)));
        send_idle_pct = 45;
        recv_idle_pct = 18;
        test_random_rules(500);

        wait_idle();
        set_config(bsrp_pkg::MAX_GENS_RST, bsrp_pkg::DEF_GENS_RST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_rules(490);

        wait_idle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[birth_survive_rule_parser_core.f]
src/bsrp_pkg.sv
src/bsrp_front.sv
src/bsrp_tok_fifo.sv
src/bsrp_back.sv
src/birth_survive_rule_parser_core.sv
src/bsrp_checker.sv
tb/tb_birth_survive_rule_parser_core.sv
